FILE: src/strs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// strs_pkg: shared types and constants of the segment tree range sum block
// Sizing of the tree store, action codes and the word formats of both
// channels.
// ============================================================================
package strs_pkg;

    // Number of leaves. Must be a power of two.
    localparam int LEAVES = 1024;
    localparam int LEAF_W = $clog2(LEAVES);
    localparam int NODES  = 2 * LEAVES;
    localparam int NODE_W = LEAF_W + 1;
    // Walk positions run up to and including 2*LEAVES.
    localparam int POS_W  = LEAF_W + 2;
    localparam int S_W    = $clog2(LEAF_W + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] ACT_UPDATE  = 2'd0;
    localparam logic [1:0] ACT_QUERY   = 2'd1;
    localparam logic [1:0] ACT_WRITE   = 2'd2;
    localparam logic [1:0] ACT_REBUILD = 2'd3;

    typedef struct packed {
        logic [1:0]               action;
        logic [9:0]               index;
        logic [10:0]              range_end;
        logic signed [DATA_W-1:0] leaf_value;
    } strs_in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] range_sum;
        logic                     is_query_answer;
    } strs_out_word_t;

    // One step of the query walk: the node to read and where the walk goes.
    typedef struct packed {
        logic              more;
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  next_pos;
    } strs_span_t;

endpackage
`default_nettype wire

FILE: src/segment_tree_range_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// segment_tree_range_sum: segment tree with point update and range sum
// Binary segment tree of LEAVES 32-bit leaves with wrapping sums, held in
// one node memory and worked by a single adder under a small sequencer.
// ============================================================================
//
//   Channel | Ports                    | Word            | Direction
//   --------+--------------------------+-----------------+----------
//   input   | s_valid, s_ready, s_word | strs_in_word_t  | in
//   result  | m_valid, m_ready, m_word | strs_out_word_t | out
//
// Each accepted word gives exactly one result word. The node memory does one
// write and up to two reads per cycle, and every action is a walk over it:
// a leaf-only write sets the leaf alone, an update climbs from the leaf
// to the root (one tree level per cycle), a query reads the nodes of the
// range (one stored node per cycle), and a rebuild redoes all inner nodes.
// After reset a clearing pass writes zero to all 2*LEAVES nodes, one per
// cycle, and s_ready stays low until that pass is done.
// The result waits in an output register, so a stalled m_ready only holds
// the engine once a second result is ready behind it.
//
module segment_tree_range_sum import strs_pkg::*; (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  strs_in_word_t  s_word,
    output logic           m_valid,
    input  wire            m_ready,
    output strs_out_word_t m_word
);

    logic           eng_idle;
    logic           eng_start;
    logic           res_valid;
    logic           res_ready;
    strs_out_word_t res;

    logic           m_valid_reg, m_valid_next;
    strs_out_word_t m_word_reg, m_word_next;

    // The engine takes a new word only when it is idle; it holds its result
    // until the output register has room for it.
    assign s_ready   = eng_idle;
    assign eng_start = s_valid && eng_idle;
    assign res_ready = !m_valid_reg || m_ready;

    strs_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .item      (s_word),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads when empty or when its word leaves this cycle.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_word_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule
`default_nettype wire

FILE: src/strs_span.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// strs_span: block search of the range query walk
// Finds the largest aligned block that starts at the walk position and ends
// at or before the limit, and gives its node and the following position.
// ============================================================================
module strs_span import strs_pkg::*; (
    input  logic [POS_W-1:0] pos,
    input  logic [POS_W-1:0] lim,
    output strs_span_t       span
);

    logic [POS_W-1:0] diff;
    logic [POS_W-1:0] blk;
    logic [S_W-1:0]   sh;

    // Both conditions hold for every size below a size where they hold, so
    // the last size that passes is the largest one.
    always_comb begin
        diff = lim - pos;
        blk  = '0;
        sh   = '0;
        for (int s = 1; s < LEAF_W; s++) begin
            blk = POS_W'(1) << s;
            if (((pos & (blk - POS_W'(1))) == '0) && (diff >= blk)) begin
                sh = S_W'(s);
            end
        end
    end

    assign span.more     = (pos < lim);
    assign span.node     = NODE_W'(pos >> sh);
    assign span.next_pos = pos + (POS_W'(1) << sh);

endmodule
`default_nettype wire

FILE: src/strs_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// strs_engine: tree store, shared adder and sequencer
// Holds the node memory and runs each action as a series of memory reads
// and writes around one 32-bit adder.
// ============================================================================
module strs_engine import strs_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  strs_in_word_t  item,
    output logic           idle,
    output logic           res_valid,
    input  logic           res_ready,
    output strs_out_word_t res
);

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_UPDATE  = 6'b000100,
        ST_QUERY   = 6'b001000,
        ST_REBUILD = 6'b010000,
        ST_DONE    = 6'b100000
    } strs_state_t;

    strs_state_t       state_reg, state_next;
    logic [NODE_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  lim_reg, lim_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [LEAF_W-1:0] reb_k_reg, reb_k_next;
    logic [LEAF_W-1:0] reb_wk_reg, reb_wk_next;
    strs_out_word_t    res_reg, res_next;

    logic [DATA_W-1:0] mem [0:NODES-1];
    logic [DATA_W-1:0] rd_a_raw_reg, rd_b_raw_reg, wr_data_q_reg;
    logic              byp_a_reg, byp_b_reg;

    logic              wr_en;
    logic [NODE_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [DATA_W-1:0] wr_data, rd_a, rd_b, op_a, sum;

    logic [LEAF_W-1:0] leaf_off;
    logic [NODE_W-1:0] leaf_node;
    logic [31:0]       end_ext, end_sat;
    logic [POS_W-1:0]  parent;
    strs_span_t        span;

    strs_span u_span (
        .pos  (pos_reg),
        .lim  (lim_reg),
        .span (span)
    );

    // Decode of the incoming word. The index wraps to the leaf count and the
    // range end saturates at it.
    assign leaf_off  = LEAF_W'(32'(item.index) & 32'(LEAVES - 1));
    assign leaf_node = {1'b1, leaf_off};
    assign end_ext   = 32'(item.range_end);
    assign end_sat   = (end_ext > 32'(LEAVES)) ? 32'(LEAVES) : end_ext;
    assign parent    = pos_reg >> 1;

    // A read of the address written in the same cycle returns the new data.
    assign rd_a = byp_a_reg ? wr_data_q_reg : rd_a_raw_reg;
    assign rd_b = byp_b_reg ? wr_data_q_reg : rd_b_raw_reg;

    // The one adder of the block.
    assign op_a = (state_reg == ST_REBUILD) ? rd_b : acc_reg;
    assign sum  = op_a + rd_a;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pos_next     = pos_reg;
        lim_next     = lim_reg;
        acc_next     = acc_reg;
        reb_k_next   = reb_k_reg;
        reb_wk_next  = reb_wk_reg;
        res_next     = res_reg;
        wr_en        = 1'b0;
        wr_addr      = clr_cnt_reg;
        wr_data      = '0;
        rd_addr_a    = '0;
        rd_addr_b    = '0;

        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                clr_cnt_next = clr_cnt_reg + NODE_W'(1);
                if (clr_cnt_reg == NODE_W'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    case (item.action)
                        ACT_UPDATE: begin
                            wr_en      = 1'b1;
                            wr_addr    = leaf_node;
                            wr_data    = $unsigned(item.leaf_value);
                            acc_next   = $unsigned(item.leaf_value);
                            pos_next   = {1'b0, leaf_node};
                            rd_addr_a  = leaf_node ^ NODE_W'(1);
                            state_next = ST_UPDATE;
                        end
                        ACT_QUERY: begin
                            rd_addr_a  = leaf_node;
                            acc_next   = '0;
                            pos_next   = {1'b0, leaf_node} + POS_W'(1);
                            lim_next   = POS_W'(LEAVES) + POS_W'(end_sat);
                            state_next = ST_QUERY;
                        end
                        ACT_WRITE: begin
                            wr_en      = 1'b1;
                            wr_addr    = leaf_node;
                            wr_data    = $unsigned(item.leaf_value);
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            rd_addr_a   = {LEAF_W'(LEAVES - 1), 1'b0};
                            rd_addr_b   = {LEAF_W'(LEAVES - 1), 1'b1};
                            reb_wk_next = LEAF_W'(LEAVES - 1);
                            reb_k_next  = LEAF_W'(LEAVES - 2);
                            state_next  = ST_REBUILD;
                        end
                    endcase
                end
            end
            ST_UPDATE: begin
                // The child just written is carried in the accumulator, only
                // its sibling comes from the store.
                wr_en    = 1'b1;
                wr_addr  = NODE_W'(parent);
                wr_data  = sum;
                acc_next = sum;
                pos_next = parent;
                if (parent == POS_W'(1)) begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    rd_addr_a = NODE_W'(parent) ^ NODE_W'(1);
                end
            end
            ST_QUERY: begin
                acc_next = sum;
                if (span.more) begin
                    rd_addr_a = span.node;
                    pos_next  = span.next_pos;
                end else begin
                    res_next.range_sum       = $signed(sum);
                    res_next.is_query_answer = 1'b1;
                    state_next               = ST_DONE;
                end
            end
            ST_REBUILD: begin
                wr_en   = 1'b1;
                wr_addr = {1'b0, reb_wk_reg};
                wr_data = sum;
                if (reb_k_reg != '0) begin
                    rd_addr_a   = {reb_k_reg, 1'b0};
                    rd_addr_b   = {reb_k_reg, 1'b1};
                    reb_wk_next = reb_k_reg;
                    reb_k_next  = reb_k_reg - LEAF_W'(1);
                end else begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            byp_a_reg   <= 1'b0;
            byp_b_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            byp_a_reg   <= wr_en && (wr_addr == rd_addr_a);
            byp_b_reg   <= wr_en && (wr_addr == rd_addr_b);
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        lim_reg    <= lim_next;
        acc_reg    <= acc_next;
        reb_k_reg  <= reb_k_next;
        reb_wk_reg <= reb_wk_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_raw_reg  <= mem[rd_addr_a];
        rd_b_raw_reg  <= mem[rd_addr_b];
        wr_data_q_reg <= wr_data;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule
`default_nettype wire

FILE: src/strs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// strs_checker: port checks of the segment tree range sum block
// Watches the top-level ports and flags behavior the block must not show.
// ============================================================================
module strs_checker import strs_pkg::*; (
    input wire            aclk,
    input wire            aresetn,
    input wire            s_valid,
    input wire            s_ready,
    input strs_in_word_t  s_word,
    input wire            m_valid,
    input wire            m_ready,
    input strs_out_word_t m_word
);

    // A result word that is not taken stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_word)))
        else $error("result word changed or dropped while stalled");

    // Only query answers carry a sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.is_query_answer || (m_word.range_sum == '0)))
        else $error("nonzero sum on a word that answers no query");

    // The clearing pass keeps the input closed right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during the clearing pass");

    // Every action leaves the idle state once its word is accepted, so an accepted
    // word closes the input for the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after a word was accepted");

endmodule

bind segment_tree_range_sum strs_checker u_strs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
`default_nettype wire

FILE: dv/segment_tree_range_sum_check.sv
`timescale 1ns / 1ps
// ============================================================================
// segment_tree_range_sum_check: result checker for the segment tree block
// Watches both channels and keeps its own copy of the node store. It predicts
// the result word of every accepted input word and compares it, field by
// field, with the oldest result still owed.
// ============================================================================
module segment_tree_range_sum_check import strs_pkg::*; (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    input  wire            s_ready,
    input  strs_in_word_t  s_word,
    input  wire            m_valid,
    input  wire            m_ready,
    input  strs_out_word_t m_word,
    output int             pending,
    output int             failures
);

    // Node 1 is the root, leaf i sits at node LEAVES + i, node 0 is unused.
    logic [DATA_W-1:0] tree_sum [NODES];
    strs_out_word_t    owed_q [$];
    int                mismatch_count = 0;
    int                result_count = 0;

    assign failures = mismatch_count;

    task automatic report_mismatch(input string detail);
        $display("%m: result %0d: %s", result_count, detail);
        mismatch_count++;
    endtask

    function automatic logic [DATA_W-1:0] span_sum(input int unsigned first,
                                                   input int unsigned stop);
        int unsigned       pos;
        int unsigned       lim;
        int unsigned       sh;
        int unsigned       node;
        logic [DATA_W-1:0] acc;
        if (stop > LEAVES)
            stop = LEAVES;
        pos = first + LEAVES;
        lim = stop + LEAVES;
        acc = tree_sum[pos];
        pos++;
        // Step forward by the largest aligned block that still fits.
        while (pos < lim) begin
            sh = 0;
            while (sh < 30 && ((pos >> sh) & 1) == 0 && pos + (32'd1 << sh) <= lim)
                sh++;
            if (sh > 0 && pos + (32'd1 << sh) > lim)
                sh--;
            node = pos >> sh;
            if (node < NODES)
                acc += tree_sum[node];
            pos += 32'd1 << sh;
        end
        return acc;
    endfunction

    function automatic strs_out_word_t predict_result(input strs_in_word_t w);
        strs_out_word_t r;
        int             k;
        int unsigned    leaf;
        r = '0;
        leaf = w.index % LEAVES;
        case (w.action)
            ACT_UPDATE: begin
                tree_sum[LEAVES + leaf] = w.leaf_value;
                for (k = (LEAVES + leaf) >> 1; k >= 1; k = k >> 1)
                    tree_sum[k] = tree_sum[2 * k] + tree_sum[2 * k + 1];
            end
            ACT_QUERY: begin
                r.range_sum = span_sum(leaf, 32'(w.range_end));
                r.is_query_answer = 1'b1;
            end
            ACT_WRITE: begin
                tree_sum[LEAVES + leaf] = w.leaf_value;
            end
            default: begin
                for (k = LEAVES - 1; k >= 1; k--)
                    tree_sum[k] = tree_sum[2 * k] + tree_sum[2 * k + 1];
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        strs_out_word_t want;
        if (!aresetn) begin
            for (int k = 0; k < NODES; k++)
                tree_sum[k] = '0;
            owed_q.delete();
            pending <= 0;
        end else begin
            // A result never belongs to a word accepted at the same edge.
            if (m_valid && m_ready) begin
                result_count++;
                if (owed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, sum %h flag %b",
                                              m_word.range_sum, m_word.is_query_answer));
                end else begin
                    want = owed_q.pop_front();
                    if (m_word.range_sum !== want.range_sum)
                        report_mismatch($sformatf("range_sum %h, want %h",
                                                  m_word.range_sum, want.range_sum));
                    if (m_word.is_query_answer !== want.is_query_answer)
                        report_mismatch($sformatf("is_query_answer %b, want %b",
                                                  m_word.is_query_answer,
                                                  want.is_query_answer));
                end
            end
            if (s_valid && s_ready)
                owed_q.push_back(predict_result(s_word));
            pending <= owed_q.size();
        end
    end

endmodule

FILE: dv/segment_tree_range_sum_test.sv
`timescale 1ns / 1ps
// ============================================================================
// segment_tree_range_sum_test: testbench top for the segment tree block
// Drives a directed opening of edge cases, then 1230 random actions
// with random gaps on both channels, and gives the verdict from the checker.
// ============================================================================
module segment_tree_range_sum_test import strs_pkg::*;;

    // Longest run of cycles with no word moving on either channel. The clearing
    // pass after reset and a rebuild are the longest quiet runs, and this limit
    // leaves a wide margin over them in any correct run.
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_WORDS = 1230;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    strs_in_word_t  s_word = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    strs_out_word_t m_word;

    int             pending;
    int             failures;
    int             idle_cycles = 0;
    // While set, neither side inserts gaps or stalls.
    logic           steady = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    segment_tree_range_sum dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    segment_tree_range_sum_check sum_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word),
        .pending  (pending),
        .failures (failures)
    );

    // Outside steady runs the receiver stalls with a chance of 15 in a hundred.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 15);
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("segment_tree_range_sum_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one word and returns at the edge that accepts it. Valid is left
    // high there, so back-to-back words need no extra assignment; a gap or a
    // pause lowers it first.
    task automatic send_word(input logic [1:0] act, input logic [9:0] idx,
                             input logic [10:0] stop, input logic [31:0] value);
        if (!steady && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_valid <= 1'b1;
        s_word <= '{action: act, index: idx, range_end: stop, leaf_value: value};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering words and waits until every owed result has come back.
    // The first edge lets the checker count the word accepted last.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        logic [1:0]  act;
        logic [9:0]  idx;
        logic [10:0] stop;
        logic [31:0] value;
        int          pick;
        int          hot_base;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // The fresh tree must read all zeros, even over the whole range.
        send_word(ACT_QUERY, 10'd0, 11'd1024, 32'h0);
        // Extreme values at both ends so that the root sum wraps.
        send_word(ACT_UPDATE, 10'd0, 11'd0, 32'h7fff_ffff);
        send_word(ACT_UPDATE, 10'd1023, 11'd2047, 32'h8000_0000);
        send_word(ACT_UPDATE, 10'd1, 11'd5, 32'hffff_ffff);
        send_word(ACT_UPDATE, 10'd512, 11'd1024, 32'h0000_0001);
        send_word(ACT_QUERY, 10'd0, 11'd1024, 32'h0);
        send_word(ACT_QUERY, 10'd0, 11'd1, 32'h0);
        send_word(ACT_QUERY, 10'd1023, 11'd1024, 32'h0);
        // A reversed range and an empty range both give the leaf alone.
        send_word(ACT_QUERY, 10'd600, 11'd5, 32'h0);
        send_word(ACT_QUERY, 10'd1, 11'd1, 32'h0);
        send_word(ACT_QUERY, 10'd1023, 11'd0, 32'h0);
        // An end past the last leaf saturates there.
        send_word(ACT_QUERY, 10'd3, 11'd2047, 32'h0);
        send_word(ACT_QUERY, 10'd1023, 11'd2047, 32'h0);
        send_word(ACT_QUERY, 10'd3, 11'd777, 32'h0);
        // A leaf-only write leaves the ancestors stale: a query over the full
        // range reads the old internal sums, while the leaf itself is new.
        send_word(ACT_WRITE, 10'd5, 11'd0, 32'h1234_5678);
        send_word(ACT_QUERY, 10'd0, 11'd1024, 32'h0);
        send_word(ACT_QUERY, 10'd4, 11'd8, 32'h0);
        send_word(ACT_QUERY, 10'd5, 11'd6, 32'h0);
        send_word(ACT_REBUILD, 10'd0, 11'd0, 32'h0);
        send_word(ACT_QUERY, 10'd0, 11'd1024, 32'h0);
        send_word(ACT_QUERY, 10'd4, 11'd8, 32'h0);
        send_word(ACT_UPDATE, 10'd0, 11'd0, 32'h0);
        send_word(ACT_QUERY, 10'd0, 11'd513, 32'h0);
        wait_drained();

        hot_base = $urandom_range(1008);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= 400 && n < 650);
            if (n % 100 == 0)
                hot_base = $urandom_range(1008);

            pick = $urandom_range(99);
            if (pick < 42)
                act = ACT_UPDATE;
            else if (pick < 84)
                act = ACT_QUERY;
            else if (pick < 97)
                act = ACT_WRITE;
            else
                act = ACT_REBUILD;

            // A small hot window makes writes and queries land on each other.
            pick = $urandom_range(99);
            if (pick < 25)
                idx = 10'(hot_base + $urandom_range(15));
            else if (pick < 30)
                idx = $urandom_range(1) ? 10'd1023 : 10'd0;
            else
                idx = 10'($urandom_range(1023));

            pick = $urandom_range(99);
            if (pick < 50)
                stop = 11'($urandom_range(1024, idx + 1));
            else if (pick < 65)
                stop = (idx < hot_base) ? 11'(hot_base + $urandom_range(16))
                                        : 11'(idx + 1 + $urandom_range(15));
            else if (pick < 75)
                stop = 11'($urandom_range(idx, 0));
            else if (pick < 85)
                stop = 11'($urandom_range(2047, 1025));
            else
                stop = 11'($urandom_range(2047));

            pick = $urandom_range(99);
            if (pick < 3)
                value = 32'h7fff_ffff;
            else if (pick < 6)
                value = 32'h8000_0000;
            else if (pick < 8)
                value = 32'hffff_ffff;
            else if (pick < 10)
                value = 32'h0;
            else
                value = $urandom;

            send_word(act, idx, stop, value);
            if (n == 800)
                wait_drained();
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (failures == 0 && pending == 0)
            $display("segment_tree_range_sum_test: done, clean");
        else
            $display("segment_tree_range_sum_test: done, errors");
        $finish;
    end

endmodule
